@@ hdl/lpht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    localparam int KEY_W  = 32;
    localparam int WORD_W = 64;
    localparam int SIZE_W = 11;
    localparam int STAT_W = 2;
    localparam int CNT_W  = $clog2(KEY_W);

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [STAT_W-1:0] status_t;

    typedef struct packed {
        word_t first_extra;
        word_t second_extra;
        word_t element_value;
    } entry_data_t;

    localparam int DATA_W = $bits(entry_data_t);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    localparam status_t STAT_OK   = 2'd0;
    localparam status_t STAT_FULL = 2'd1;
    localparam status_t STAT_ZERO = 2'd2;

    localparam size_t TABLE_SIZE_RESET = 11'd1024;

endpackage

`default_nettype wire

@@ hdl/lpht_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

@@ hdl/lpht_mod.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpht_mod
    import lpht_pkg::*;
#(
    parameter int MW = 11
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire key_t          dividend,
    input  wire logic [MW-1:0] divisor,
    output logic               done,
    output logic      [MW-1:0] remainder
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MW-1:0]    rem_reg, rem_next;
    key_t             dvd_reg, dvd_next;
    logic [MW-1:0]    div_reg, div_next;
    logic [MW:0]      trial;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KEY_W - 1);

    // one restoring step per cycle, msb of the dividend first
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[KEY_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = MW'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[MW-1:0];
            end
            dvd_next = {dvd_reg[KEY_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ hdl/linear_probe_hash_table_unit.sv @@
// Open-addressing hash table with linear probing.
// Input channel (in_valid / in_stall): req_type 0 inserts key with its three data
// words, req_type 1 searches for key. Unless a table_size write drops it, every
// item gives exactly one result on the output channel (out_valid / out_stall):
// found, status, the hit entry and the entry count after the item. Key zero
// marks an empty slot; inserting it gives status 2, inserting into a full table
// gives status 1. The home slot, key mod the slots in use, comes from a
// bit-serial remainder unit, then each probe is a registered read of the
// single-port slot memory followed by a compare. The next item is taken the
// cycle after its result is loaded, and a key zero insert skips the remainder
// unit. One item is worked on at a time.
// Config channel (cfg_valid / cfg_ready, always ready): writing table_size clears
// the table and the entry count.
// After reset and after every table_size write a clearing pass over all CAPACITY
// slots zeroes the key memory; in_stall stays high during it.
// A finished result sits in the output register while out_stall is high; the
// next item is accepted meanwhile but holds its result until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               req_type,
    input  wire logic [31:0]        key,
    input  wire logic signed [63:0] first_extra,
    input  wire logic signed [63:0] second_extra,
    input  wire logic signed [63:0] element_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    found,
    output logic [1:0]              status,
    output logic [31:0]             hit_key,
    output logic signed [63:0]      hit_first_extra,
    output logic signed [63:0]      hit_second_extra,
    output logic signed [63:0]      hit_element,
    output logic [10:0]             entry_count,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [10:0]        table_size
);

    localparam int AW = $clog2(CAPACITY);
    localparam int MW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(CAPACITY - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_REJECT = 3'd5;

    logic [2:0]    state_reg, state_next;
    size_t         size_reg, size_next;
    size_t         count_reg, count_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [MW-1:0] probe_reg, probe_next;

    logic          req_type_reg;
    key_t          key_reg;
    entry_data_t   req_data_reg;

    logic          out_valid_reg;
    logic          found_reg;
    status_t       status_reg;
    key_t          hit_key_reg;
    entry_data_t   hit_data_reg;
    size_t         count_out_reg;

    logic          in_accept, cfg_accept, out_free;
    logic          mod_start, mod_done;
    logic [MW-1:0] mod_rem;
    logic [MW-1:0] slots;
    logic [MW-1:0] pos_inc;
    logic [AW-1:0] pos_wrap;
    logic          last_probe, slot_empty, key_match;

    logic          key_we, ins_write;
    logic [AW-1:0] key_addr;
    key_t          key_wdata, key_rdata;
    entry_data_t   data_rdata;

    logic          emit;
    logic          res_found;
    status_t       res_status;
    key_t          res_key;
    entry_data_t   res_data;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !out_valid_reg || !out_stall;

    // slots in use, zero acts as one and anything past the capacity as the capacity
    always_comb
    begin
        if (size_reg == '0)
        begin
            slots = MW'(1);
        end
        else if (32'(size_reg) > 32'(CAPACITY))
        begin
            slots = MW'(CAPACITY);
        end
        else
        begin
            slots = MW'(size_reg);
        end
    end

    assign mod_start = in_accept && !(req_type == REQ_INSERT && key == '0);

    lpht_mod #(
        .MW(MW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (key),
        .divisor  (slots),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    assign key_we    = (state_reg == S_CLEAR) || ins_write;
    assign key_addr  = (state_reg == S_CLEAR) ? clr_reg : pos_reg;
    assign key_wdata = (state_reg == S_CLEAR) ? '0 : key_reg;

    lpht_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_key_ram (
        .clk  (clk),
        .we   (key_we),
        .addr (key_addr),
        .wdata(key_wdata),
        .rdata(key_rdata)
    );

    lpht_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_data_ram (
        .clk  (clk),
        .we   (ins_write),
        .addr (pos_reg),
        .wdata(req_data_reg),
        .rdata(data_rdata)
    );

    assign pos_inc    = MW'(pos_reg) + 1'b1;
    assign pos_wrap   = (pos_inc == slots) ? '0 : pos_inc[AW-1:0];
    assign last_probe = ((probe_reg + 1'b1) == slots);
    assign slot_empty = (key_rdata == '0);
    assign key_match  = (key_rdata == key_reg);

    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        count_next = count_reg;
        clr_next   = clr_reg;
        pos_next   = pos_reg;
        probe_next = probe_reg;
        ins_write  = 1'b0;
        emit       = 1'b0;
        res_found  = 1'b0;
        res_status = STAT_OK;
        res_key    = '0;
        res_data   = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = mod_start ? S_DIV : S_REJECT;
                end
            end
            S_DIV:
            begin
                if (mod_done)
                begin
                    pos_next   = mod_rem[AW-1:0];
                    probe_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (req_type_reg == REQ_INSERT)
                begin
                    priority if (slot_empty)
                    begin
                        if (out_free)
                        begin
                            ins_write  = 1'b1;
                            count_next = count_reg + 1'b1;
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else if (last_probe)
                    begin
                        if (out_free)
                        begin
                            res_status = STAT_FULL;
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        pos_next   = pos_wrap;
                        probe_next = probe_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    if (slot_empty || key_match || last_probe)
                    begin
                        if (out_free)
                        begin
                            // an empty slot ends the chain before key zero can match
                            if (!slot_empty && key_match)
                            begin
                                res_found = 1'b1;
                                res_key   = key_rdata;
                                res_data  = data_rdata;
                            end
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        pos_next   = pos_wrap;
                        probe_next = probe_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_REJECT:
            begin
                if (out_free)
                begin
                    res_status = STAT_ZERO;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_accept)
        begin
            size_next  = table_size;
            count_next = '0;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            size_reg      <= TABLE_SIZE_RESET;
            count_reg     <= '0;
            clr_reg       <= '0;
            pos_reg       <= '0;
            probe_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
            pos_reg   <= pos_next;
            probe_reg <= probe_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_type_reg               <= req_type;
            key_reg                    <= key;
            req_data_reg.first_extra   <= $unsigned(first_extra);
            req_data_reg.second_extra  <= $unsigned(second_extra);
            req_data_reg.element_value <= $unsigned(element_value);
        end
        if (emit)
        begin
            found_reg     <= res_found;
            status_reg    <= res_status;
            hit_key_reg   <= res_key;
            hit_data_reg  <= res_data;
            count_out_reg <= count_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign found            = found_reg;
    assign status           = status_reg;
    assign hit_key          = hit_key_reg;
    assign hit_first_extra  = $signed(hit_data_reg.first_extra);
    assign hit_second_extra = $signed(hit_data_reg.second_extra);
    assign hit_element      = $signed(hit_data_reg.element_value);
    assign entry_count      = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(slots))
        else $error("entry count exceeds slots in use");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (32'(pos_reg) < 32'(slots)))
        else $error("probe position outside the table");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(state_reg) == S_CHECK || $past(state_reg) == S_REJECT))
        else $error("result raised outside a finishing state");

endmodule

`default_nettype wire
